/* design/i2c_bus_recovery_sequencer_defines.svh */
// assertion macros for the i2c bus recovery sequencer
// no dependencies; included by the modules that carry assertions
`ifndef I2C_BUS_RECOVERY_SEQUENCER_DEFINES_SVH
`define I2C_BUS_RECOVERY_SEQUENCER_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked out of reset
`define I2CBR_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("i2cbr assertion failed");

// next-cycle implication, checked out of reset
`define I2CBR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("i2cbr assertion failed");

`else

`define I2CBR_ASSERT(lbl, ante, cons)
`define I2CBR_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

/* design/i2cbr_pkg.sv */
// shared types, constants and helpers for the i2c bus recovery sequencer
// no dependencies
package i2cbr_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int TIMEOUT_W   = 16;
    localparam int CMP_W       = (COUNT_WIDTH > TIMEOUT_W) ? COUNT_WIDTH : TIMEOUT_W;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(9);

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [TIMEOUT_W-1:0]   timeout_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_CHECK,
        PH_WAIT,
        PH_REL,
        PH_E1,
        PH_E2,
        PH_E3
    } phase_t;

    // one input request
    typedef struct packed {
        logic command;
        logic sda_level;
        logic scl_level;
    } item_t;

    // one result
    typedef struct packed {
        logic scl_drive;
        logic sda_drive;
        logic busy_res;
        logic done_res;
        logic success;
    } result_t;

    // counter has hit the timeout or saturated
    function automatic logic at_limit(count_t c, timeout_t t);
        at_limit = (CMP_W'(c) >= CMP_W'(t)) || (c == '1);
    endfunction

endpackage

/* design/i2cbr_fsm.sv */
// recovery state machine: phase, pulse and stretch counters, line drives
// depends on i2cbr_pkg and i2c_bus_recovery_sequencer_defines.svh
`include "i2c_bus_recovery_sequencer_defines.svh"

module i2cbr_fsm (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [15:0]       cfg_wr_data,
    input  logic              step,
    input  i2cbr_pkg::item_t  item,
    output i2cbr_pkg::result_t result
);

    i2cbr_pkg::phase_t   phase_reg, phase_next;
    i2cbr_pkg::count_t   pulse_reg, pulse_next;
    i2cbr_pkg::count_t   stretch_reg, stretch_next;
    i2cbr_pkg::timeout_t timeout_reg;
    logic                scl_reg, scl_next;
    logic                sda_reg, sda_next;
    logic                fail;
    logic                done;
    logic                ok;

    // timeout register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= i2cbr_pkg::TIMEOUT_RESET;
        end else if (cfg_wr_en) begin
            timeout_reg <= cfg_wr_data;
        end
    end

    // timeout detection for this request
    always_comb begin
        fail = 1'b0;
        if (!item.command) begin
            case (phase_reg)
                i2cbr_pkg::PH_CHECK: begin
                    if (!item.sda_level) begin
                        if (i2cbr_pkg::at_limit(pulse_reg, timeout_reg)) begin
                            fail = 1'b1;
                        end else if (!item.scl_level &&
                                     i2cbr_pkg::at_limit('0, timeout_reg)) begin
                            fail = 1'b1;
                        end
                    end
                end
                i2cbr_pkg::PH_WAIT: begin
                    fail = !item.scl_level &&
                           i2cbr_pkg::at_limit(stretch_reg, timeout_reg);
                end
                default: fail = 1'b0;
            endcase
        end
    end

    // next phase
    always_comb begin
        phase_next = phase_reg;
        if (item.command) begin
            phase_next = i2cbr_pkg::PH_CHECK;
        end else if (fail) begin
            phase_next = i2cbr_pkg::PH_IDLE;
        end else begin
            case (phase_reg)
                i2cbr_pkg::PH_IDLE:  phase_next = i2cbr_pkg::PH_IDLE;
                i2cbr_pkg::PH_CHECK: begin
                    if (item.sda_level) begin
                        phase_next = i2cbr_pkg::PH_E1;
                    end else if (item.scl_level) begin
                        phase_next = i2cbr_pkg::PH_REL;
                    end else begin
                        phase_next = i2cbr_pkg::PH_WAIT;
                    end
                end
                i2cbr_pkg::PH_WAIT: begin
                    if (item.scl_level) begin
                        phase_next = i2cbr_pkg::PH_REL;
                    end
                end
                i2cbr_pkg::PH_REL:   phase_next = i2cbr_pkg::PH_CHECK;
                i2cbr_pkg::PH_E1:    phase_next = i2cbr_pkg::PH_E2;
                i2cbr_pkg::PH_E2:    phase_next = i2cbr_pkg::PH_E3;
                i2cbr_pkg::PH_E3:    phase_next = i2cbr_pkg::PH_IDLE;
                default:             phase_next = i2cbr_pkg::PH_IDLE;
            endcase
        end
    end

    // counters, drives and completion flags
    always_comb begin
        pulse_next   = pulse_reg;
        stretch_next = stretch_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        done         = 1'b0;
        ok           = 1'b0;
        if (item.command) begin
            pulse_next   = '0;
            stretch_next = '0;
            scl_next     = 1'b1;
            sda_next     = 1'b1;
        end else begin
            case (phase_reg)
                i2cbr_pkg::PH_CHECK: begin
                    if (item.sda_level) begin
                        sda_next = 1'b0;
                    end else if (!i2cbr_pkg::at_limit(pulse_reg, timeout_reg)) begin
                        if (item.scl_level) begin
                            stretch_next = '0;
                            scl_next     = 1'b0;
                        end else begin
                            stretch_next = i2cbr_pkg::COUNT_WIDTH'(1);
                        end
                    end
                end
                i2cbr_pkg::PH_WAIT: begin
                    if (item.scl_level) begin
                        scl_next = 1'b0;
                    end else begin
                        stretch_next = stretch_reg + i2cbr_pkg::COUNT_WIDTH'(1);
                    end
                end
                i2cbr_pkg::PH_REL: begin
                    scl_next = 1'b1;
                    if (pulse_reg != '1) begin
                        pulse_next = pulse_reg + i2cbr_pkg::COUNT_WIDTH'(1);
                    end
                end
                i2cbr_pkg::PH_E1: scl_next = 1'b0;
                i2cbr_pkg::PH_E2: scl_next = 1'b1;
                i2cbr_pkg::PH_E3: begin
                    sda_next = 1'b1;
                    done     = 1'b1;
                    ok       = 1'b1;
                end
                default: begin
                    done = 1'b0;
                end
            endcase
            // timeout releases both lines
            if (fail) begin
                scl_next = 1'b1;
                sda_next = 1'b1;
                done     = 1'b1;
                ok       = 1'b0;
            end
        end
    end

    // result of this request
    always_comb begin
        result.scl_drive = scl_next;
        result.sda_drive = sda_next;
        result.busy_res  = (phase_next != i2cbr_pkg::PH_IDLE);
        result.done_res  = done;
        result.success   = ok;
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= i2cbr_pkg::PH_IDLE;
            pulse_reg   <= '0;
            stretch_reg <= '0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
        end else if (step) begin
            phase_reg   <= phase_next;
            pulse_reg   <= pulse_next;
            stretch_reg <= stretch_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
        end
    end

    `I2CBR_ASSERT(a_idle_released, phase_reg == i2cbr_pkg::PH_IDLE, scl_reg && sda_reg)
    `I2CBR_ASSERT(a_wait_counting, phase_reg == i2cbr_pkg::PH_WAIT, stretch_reg != '0)
    `I2CBR_ASSERT_NXT(a_stop_ends, step && !item.command && phase_reg == i2cbr_pkg::PH_E3, phase_reg == i2cbr_pkg::PH_IDLE && sda_reg)

endmodule

/* design/i2cbr_out_stage.sv */
// result register with valid/ready toward the consumer
// depends on i2cbr_pkg
module i2cbr_out_stage (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  i2cbr_pkg::result_t  data_in,
    input  logic                m_ready,
    output logic                free,
    output logic                m_valid,
    output i2cbr_pkg::result_t  data_out
);

    logic               valid_reg;
    i2cbr_pkg::result_t data_reg;

    // room for a new result when empty or draining this cycle
    assign free = !valid_reg || m_ready;

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_in;
        end
    end

    assign m_valid  = valid_reg;
    assign data_out = data_reg;

endmodule

/* design/i2c_bus_recovery_sequencer.sv */
// top level of the i2c bus recovery sequencer: input register, fsm, result register
// depends on i2cbr_pkg, i2cbr_fsm, i2cbr_out_stage and the defines header
//
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    s_command, s_sda_level, s_scl_level
//  m_        out        m_valid / m_ready    m_scl_drive, m_sda_drive, m_busy_res,
//                                            m_done_res, m_success
//  cfg_      in         cfg_wr_en            cfg_wr_data (timeout_cycles)
//
// one request per cycle sustained while m_ready is high; a request in the input register
// gets its fsm update into the result register as soon as that register has room.
// synchronous active-low reset returns the fsm to idle with both lines released
// and the timeout at 9. a stalled result holds the result register, and the
// input register keeps taking requests until both stages are full.
`include "i2c_bus_recovery_sequencer_defines.svh"

module i2c_bus_recovery_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic        s_sda_level,
    input  logic        s_scl_level,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_scl_drive,
    output logic        m_sda_drive,
    output logic        m_busy_res,
    output logic        m_done_res,
    output logic        m_success
);

    logic               in_valid_reg;
    i2cbr_pkg::item_t   item_reg;
    logic               out_free;
    logic               adv;
    i2cbr_pkg::result_t fsm_result;
    i2cbr_pkg::result_t out_result;

    // request moves from input register into the result register
    assign adv     = in_valid_reg && out_free;
    assign s_ready = !in_valid_reg || adv;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.command   <= s_command;
            item_reg.sda_level <= s_sda_level;
            item_reg.scl_level <= s_scl_level;
        end
    end

    // recovery state machine
    i2cbr_fsm u_fsm (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step        (adv),
        .item        (item_reg),
        .result      (fsm_result)
    );

    // result register
    i2cbr_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (adv),
        .data_in  (fsm_result),
        .m_ready  (m_ready),
        .free     (out_free),
        .m_valid  (m_valid),
        .data_out (out_result)
    );

    assign m_scl_drive = out_result.scl_drive;
    assign m_sda_drive = out_result.sda_drive;
    assign m_busy_res  = out_result.busy_res;
    assign m_done_res  = out_result.done_res;
    assign m_success   = out_result.success;

    `I2CBR_ASSERT_NXT(a_adv_fills_out, adv, m_valid)
    `I2CBR_ASSERT(a_success_with_done, m_valid && m_success, m_done_res && m_sda_drive)
    `I2CBR_ASSERT(a_done_not_busy, m_valid && m_done_res, !m_busy_res && m_scl_drive)

endmodule

/* test/tb_top.sv */
// self-checking testbench for the i2c bus recovery sequencer
// depends on i2cbr_pkg and the i2c_bus_recovery_sequencer top level
// checks every result against a cycle-free model of the bus-clear state machine

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned MAX_SHOWN   = 10;

    // clock, reset and block ports
    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = 16'd0;
    logic        s_valid     = 1'b0;
    logic        s_ready;
    logic        s_command   = 1'b0;
    logic        s_sda_level = 1'b0;
    logic        s_scl_level = 1'b0;
    logic        m_valid;
    logic        m_ready     = 1'b0;
    logic        m_scl_drive;
    logic        m_sda_drive;
    logic        m_busy_res;
    logic        m_done_res;
    logic        m_success;

    // stimulus and scoreboard storage
    i2cbr_pkg::item_t   req_pending_q[$];
    i2cbr_pkg::result_t drive_expect_q[$];
    logic               req_taken   = 1'b0;
    int unsigned        idle_pct    = 29;
    int unsigned        cycle_cnt   = 0;
    int unsigned        mismatch_cnt = 0;
    i2cbr_pkg::item_t   next_req;

    // bus-clear model state
    i2cbr_pkg::phase_t   seq_phase;
    i2cbr_pkg::count_t   pulse_cnt;
    i2cbr_pkg::count_t   stretch_cnt;
    i2cbr_pkg::timeout_t timeout_val;
    logic                scl_hold;
    logic                sda_hold;

    i2c_bus_recovery_sequencer u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_sda_level (s_sda_level),
        .s_scl_level (s_scl_level),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_scl_drive (m_scl_drive),
        .m_sda_drive (m_sda_drive),
        .m_busy_res  (m_busy_res),
        .m_done_res  (m_done_res),
        .m_success   (m_success)
    );

    // 20 ns clock
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // counter reached the timeout, or saturated
    function automatic logic limit_hit(i2cbr_pkg::count_t c);
        return (c >= i2cbr_pkg::count_t'(timeout_val)) || (&c);
    endfunction

    // advance the bus-clear machine by one request and return the drives it leaves
    function automatic i2cbr_pkg::result_t bus_clear_step(i2cbr_pkg::item_t req);
        i2cbr_pkg::result_t r;
        logic               timed_out;
        r = '0;
        timed_out = 1'b0;
        if (req.command) begin
            seq_phase   = i2cbr_pkg::PH_CHECK;
            pulse_cnt   = '0;
            stretch_cnt = '0;
            scl_hold    = 1'b1;
            sda_hold    = 1'b1;
        end else begin
            case (seq_phase)
                i2cbr_pkg::PH_IDLE: begin
                    // ticks while idle change nothing
                end
                i2cbr_pkg::PH_CHECK: begin
                    if (req.sda_level) begin
                        sda_hold  = 1'b0;
                        seq_phase = i2cbr_pkg::PH_E1;
                    end else if (limit_hit(pulse_cnt)) begin
                        timed_out = 1'b1;
                    end else begin
                        stretch_cnt = '0;
                        if (req.scl_level) begin
                            scl_hold  = 1'b0;
                            seq_phase = i2cbr_pkg::PH_REL;
                        end else if (limit_hit(stretch_cnt)) begin
                            timed_out = 1'b1;
                        end else begin
                            stretch_cnt = i2cbr_pkg::count_t'(1);
                            seq_phase   = i2cbr_pkg::PH_WAIT;
                        end
                    end
                end
                i2cbr_pkg::PH_WAIT: begin
                    if (req.scl_level) begin
                        scl_hold  = 1'b0;
                        seq_phase = i2cbr_pkg::PH_REL;
                    end else if (limit_hit(stretch_cnt)) begin
                        timed_out = 1'b1;
                    end else begin
                        stretch_cnt = stretch_cnt + 1'b1;
                    end
                end
                i2cbr_pkg::PH_REL: begin
                    scl_hold = 1'b1;
                    if (!(&pulse_cnt))
                        pulse_cnt = pulse_cnt + 1'b1;
                    seq_phase = i2cbr_pkg::PH_CHECK;
                end
                i2cbr_pkg::PH_E1: begin
                    scl_hold  = 1'b0;
                    seq_phase = i2cbr_pkg::PH_E2;
                end
                i2cbr_pkg::PH_E2: begin
                    scl_hold  = 1'b1;
                    seq_phase = i2cbr_pkg::PH_E3;
                end
                i2cbr_pkg::PH_E3: begin
                    sda_hold   = 1'b1;
                    r.done_res = 1'b1;
                    r.success  = 1'b1;
                    seq_phase  = i2cbr_pkg::PH_IDLE;
                end
                default: begin
                    seq_phase = i2cbr_pkg::PH_IDLE;
                end
            endcase
            // failure releases both lines
            if (timed_out) begin
                scl_hold   = 1'b1;
                sda_hold   = 1'b1;
                r.done_res = 1'b1;
                r.success  = 1'b0;
                seq_phase  = i2cbr_pkg::PH_IDLE;
            end
        end
        r.scl_drive = scl_hold;
        r.sda_drive = sda_hold;
        r.busy_res  = (seq_phase != i2cbr_pkg::PH_IDLE);
        return r;
    endfunction

    // request driver and result-side ready, both on the falling edge
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !req_taken) begin
            // hold the current request until it is taken
        end else if (req_pending_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
            next_req    = req_pending_q.pop_front();
            s_valid     <= 1'b1;
            s_command   <= next_req.command;
            s_sda_level <= next_req.sda_level;
            s_scl_level <= next_req.scl_level;
        end else begin
            s_valid <= 1'b0;
        end
        m_ready <= ($urandom_range(99) >= idle_pct);
    end

    // request acceptance feeds the model
    always @(posedge aclk) begin
        req_taken <= aresetn && s_valid && (s_ready === 1'b1);
        if (aresetn && s_valid && s_ready === 1'b1)
            drive_expect_q.push_back(bus_clear_step('{s_command, s_sda_level, s_scl_level}));
    end

    // result monitor
    always @(posedge aclk) begin
        i2cbr_pkg::result_t got;
        i2cbr_pkg::result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            got = '{m_scl_drive, m_sda_drive, m_busy_res, m_done_res, m_success};
            if (drive_expect_q.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= MAX_SHOWN)
                    $display("%0t: result with nothing expected: scl %b sda %b busy %b done %b ok %b",
                             $realtime, got.scl_drive, got.sda_drive, got.busy_res,
                             got.done_res, got.success);
            end else begin
                want = drive_expect_q.pop_front();
                if (got.scl_drive !== want.scl_drive || got.sda_drive !== want.sda_drive ||
                    got.busy_res !== want.busy_res || got.done_res !== want.done_res ||
                    got.success !== want.success) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_SHOWN)
                        $display("%0t: mismatch scl/sda/busy/done/ok expected %b%b%b%b%b got %b%b%b%b%b",
                                 $realtime, want.scl_drive, want.sda_drive, want.busy_res,
                                 want.done_res, want.success, got.scl_drive, got.sda_drive,
                                 got.busy_res, got.done_res, got.success);
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // queue one request
    function automatic void push_req(logic cmd, logic sda, logic scl);
        i2cbr_pkg::item_t it;
        it.command   = cmd;
        it.sda_level = sda;
        it.scl_level = scl;
        req_pending_q.push_back(it);
    endfunction

    // start request followed by ticks with biased line levels; returns requests queued
    function automatic int unsigned queue_recovery(int unsigned sda_low_pct,
                                                   int unsigned scl_low_pct,
                                                   int unsigned ticks);
        push_req(1'b1, 1'($urandom_range(1)), 1'($urandom_range(1)));
        repeat (ticks)
            push_req(1'b0, 1'($urandom_range(99) >= sda_low_pct),
                     1'($urandom_range(99) >= scl_low_pct));
        return ticks + 1;
    endfunction

    // mix of full sequences, short aborted ones and noise
    task automatic queue_traffic(int unsigned n);
        int unsigned added;
        int unsigned pick;
        int unsigned k;
        added = 0;
        while (added < n) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                // long clock stretch, aims at the stretch limit
                added += queue_recovery(90, 92, $urandom_range(10, 30));
            end else if (pick < 70) begin
                added += queue_recovery($urandom_range(20, 85), $urandom_range(0, 50),
                                        $urandom_range(4, 24));
            end else if (pick < 85) begin
                // cut short by the next start
                added += queue_recovery($urandom_range(0, 100), $urandom_range(0, 100),
                                        $urandom_range(0, 3));
            end else begin
                k = $urandom_range(1, 6);
                repeat (k)
                    push_req(1'($urandom_range(9) == 0), 1'($urandom_range(1)),
                             1'($urandom_range(1)));
                added += k;
            end
        end
    endtask

    // wait until every request is taken and every result is back
    // checked at the rising edge, where the driver's queue and valid are settled
    task automatic drain_all();
        do
            @(posedge aclk);
        while (req_pending_q.size() != 0 || s_valid || drive_expect_q.size() != 0);
        repeat (6) @(negedge aclk);
    endtask

    task automatic write_timeout(logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        timeout_val = val;
    endtask

    // main sequence
    initial begin
        logic [15:0] timeouts[7];
        seq_phase   = i2cbr_pkg::PH_IDLE;
        pulse_cnt   = '0;
        stretch_cnt = '0;
        scl_hold    = 1'b1;
        sda_hold    = 1'b1;
        timeout_val = i2cbr_pkg::TIMEOUT_RESET;
        timeouts    = '{16'd0, 16'd1, 16'd2, 16'd65535, 16'd3, 16'd9, 16'd0};
        timeouts[6] = 16'($urandom_range(4, 20));

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: idle ticks, clean release, pulses with stretch, restart while busy
        push_req(1'b0, 1'b0, 1'b0);
        push_req(1'b0, 1'b1, 1'b1);
        push_req(1'b1, 1'b1, 1'b1);
        push_req(1'b0, 1'b1, 1'b1);
        push_req(1'b0, 1'b0, 1'b0);
        push_req(1'b0, 1'b0, 1'b0);
        push_req(1'b0, 1'b0, 1'b0);
        push_req(1'b1, 1'b0, 1'b0);
        push_req(1'b0, 1'b0, 1'b1);
        push_req(1'b0, 1'b1, 1'b1);
        push_req(1'b0, 1'b0, 1'b0);
        push_req(1'b0, 1'b0, 1'b0);
        push_req(1'b0, 1'b0, 1'b1);
        push_req(1'b0, 1'b0, 1'b0);
        push_req(1'b0, 1'b0, 1'b1);
        push_req(1'b1, 1'b0, 1'b1);
        push_req(1'b0, 1'b1, 1'b0);
        push_req(1'b0, 1'b0, 1'b0);
        push_req(1'b0, 1'b0, 1'b0);
        push_req(1'b0, 1'b1, 1'b1);
        push_req(1'b0, 1'b0, 1'b1);
        drain_all();

        // random traffic under several timeout settings
        foreach (timeouts[i]) begin
            write_timeout(timeouts[i]);
            idle_pct = (i == 2) ? 0 : 29;
            queue_traffic(155);
            drain_all();
        end

        // back to the reset value
        write_timeout(i2cbr_pkg::TIMEOUT_RESET);
        idle_pct = 29;
        queue_traffic(40);
        drain_all();

        if (mismatch_cnt == 0 && drive_expect_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+design
design/i2cbr_pkg.sv
design/i2cbr_fsm.sv
design/i2cbr_out_stage.sv
design/i2c_bus_recovery_sequencer.sv
test/tb_top.sv
